[hdl/oss_pkg.sv]
package oss_pkg;

   // Block sizing.
   localparam int SLOTS            = 32;
   localparam int TICKS_PER_SECOND = 1000000000;
   localparam int MAX_RESULTS      = 32;

   // Field widths of one item and one result.
   localparam int CMD_W   = 2;
   localparam int SLOT_FW = 5;
   localparam int DELAY_W = 16;
   localparam int NOW_W   = 62;
   localparam int TIME_W  = 63;

   // Derived widths.
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_W = DELAY_W + TPS_W;
   localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int ROW_W  = 2 * TIME_W;

   // Stream packing.
   localparam int REQ_BITS    = CMD_W + SLOT_FW + DELAY_W + NOW_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 1 + SLOT_FW + 2 * TIME_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD     = RSP_TDATA_W - RSP_BITS;

   // Command codes carried by an input item.
   typedef enum logic [CMD_W-1:0] {
      CMD_ARM    = 2'd0,
      CMD_DISARM = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;     // item accepted: latch fields, form the arm product
      logic disarm;      // clear the active mark of the addressed slot now
      logic arm_write;   // write the timer row and set its active mark
      logic scan_start;  // begin a pass over the slot table
      logic load_best;   // move the best candidate to the output, disarm it
      logic load_none;   // load the not-fired result
      logic set_last;    // mark the output result as the final one
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_done;   // last slot of the pass has been compared
      logic found;       // a due slot has been found in this pass
   } dp_sts_type;

endpackage

[hdl/oss_dpath.sv]
module oss_dpath import oss_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_sts_type          sts,
   input  logic [SLOT_FW-1:0]  req_slot,
   input  logic [DELAY_W-1:0]  req_delay_seconds,
   input  logic [NOW_W-1:0]    req_now,
   output logic                rsp_fired,
   output logic [SLOT_FW-1:0]  rsp_fired_slot,
   output logic [TIME_W-1:0]   rsp_expiry_time,
   output logic [TIME_W-1:0]   rsp_armed_time,
   output logic                rsp_last
);

   // Timer table: one row per slot, armed time in the upper half.
   logic [ROW_W-1:0]  row_mem [SLOTS];

   logic [SLOTS-1:0]  active_ff, active_in;
   logic [NOW_W-1:0]  now_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              slot_ok_ff;
   logic [PROD_W-1:0] prod_ff;

   logic              scan_on_ff, scan_on_in;
   logic [SLOT_W-1:0] scan_idx_ff, scan_idx_in;
   logic              rd_vld_ff;
   logic [SLOT_W-1:0] rd_idx_ff;
   logic [ROW_W-1:0]  rd_row_ff;

   logic              found_ff, found_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_exp_ff, best_exp_in;
   logic [TIME_W-1:0] best_arm_ff, best_arm_in;

   logic              fired_ff;
   logic [SLOT_FW-1:0] oslot_ff;
   logic [TIME_W-1:0] oexp_ff;
   logic [TIME_W-1:0] oarm_ff;
   logic              last_ff;

   logic              req_slot_ok;
   logic [SLOT_W-1:0] req_idx;
   logic [TIME_W-1:0] arm_expiry;
   logic [TIME_W-1:0] rd_exp;
   logic [TIME_W-1:0] rd_arm;
   logic              cand;

   assign req_slot_ok = 32'(req_slot) < SLOTS;
   assign req_idx     = SLOT_W'(req_slot);
   assign arm_expiry  = TIME_W'(now_ff) + TIME_W'(prod_ff);
   assign rd_exp      = rd_row_ff[TIME_W-1:0];
   assign rd_arm      = rd_row_ff[ROW_W-1:TIME_W];

   // A slot is a candidate when it is armed, due, and strictly earlier than the
   // best so far; ascending scan order gives ties to the lower slot.
   assign cand = rd_vld_ff && active_ff[rd_idx_ff] && (rd_exp <= TIME_W'(now_ff)) &&
                 (!found_ff || (rd_exp < best_exp_ff));

   always_comb begin
      active_in = active_ff;
      if (cmd.disarm && req_slot_ok) begin
         active_in[req_idx] = 1'b0;
      end
      if (cmd.arm_write && slot_ok_ff) begin
         active_in[slot_ff] = 1'b1;
      end
      if (cmd.load_best) begin
         active_in[best_idx_ff] = 1'b0;
      end
   end

   always_comb begin
      scan_on_in  = scan_on_ff;
      scan_idx_in = scan_idx_ff;
      if (cmd.scan_start) begin
         scan_on_in  = 1'b1;
         scan_idx_in = '0;
      end else if (scan_on_ff) begin
         if (scan_idx_ff == SLOT_W'(SLOTS - 1)) begin
            scan_on_in = 1'b0;
         end else begin
            scan_idx_in = scan_idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_exp_in = best_exp_ff;
      best_arm_in = best_arm_ff;
      if (cmd.scan_start) begin
         found_in = 1'b0;
      end else if (cand) begin
         found_in    = 1'b1;
         best_idx_in = rd_idx_ff;
         best_exp_in = rd_exp;
         best_arm_in = rd_arm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         scan_on_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         active_ff  <= active_in;
         scan_on_ff <= scan_on_in;
         rd_vld_ff  <= scan_on_ff;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= scan_idx_ff;
      best_idx_ff <= best_idx_in;
      best_exp_ff <= best_exp_in;
      best_arm_ff <= best_arm_in;
      if (cmd.capture) begin
         now_ff     <= req_now;
         slot_ff    <= req_idx;
         slot_ok_ff <= req_slot_ok;
         prod_ff    <= PROD_W'(req_delay_seconds) * PROD_W'(TICKS_PER_SECOND);
      end
      if (cmd.load_best) begin
         fired_ff <= 1'b1;
         oslot_ff <= SLOT_FW'(best_idx_ff);
         oexp_ff  <= best_exp_ff;
         oarm_ff  <= best_arm_ff;
      end else if (cmd.load_none) begin
         fired_ff <= 1'b0;
         oslot_ff <= '0;
         oexp_ff  <= '0;
         oarm_ff  <= '0;
      end
      if (cmd.set_last || cmd.load_none) begin
         last_ff <= 1'b1;
      end else if (cmd.load_best) begin
         last_ff <= 1'b0;
      end
   end

   // Table write port and registered read port.
   always_ff @(posedge clock) begin
      if (cmd.arm_write && slot_ok_ff) begin
         row_mem[slot_ff] <= {TIME_W'(now_ff), arm_expiry};
      end
   end

   always_ff @(posedge clock) begin
      if (scan_on_ff) begin
         rd_row_ff <= row_mem[scan_idx_ff];
      end
   end

   assign sts.scan_done = rd_vld_ff && (rd_idx_ff == SLOT_W'(SLOTS - 1));
   assign sts.found     = found_ff;

   assign rsp_fired       = fired_ff;
   assign rsp_fired_slot  = oslot_ff;
   assign rsp_expiry_time = oexp_ff;
   assign rsp_armed_time  = oarm_ff;
   assign rsp_last        = last_ff;

   // A fired slot is disarmed once it moves to the output.
   a_fired_disarmed: assert property (@(posedge clock) disable iff (reset)
      cmd.load_best |=> !active_ff[$past(best_idx_ff)])
      else $error("fired slot still armed");

   // The read stage only runs behind an issuing scan.
   a_read_follows_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(scan_on_ff))
      else $error("table read without scan");

endmodule

[hdl/oss_ctrl.sv]
module oss_ctrl import oss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [CMD_W-1:0] req_command,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output dp_cmd_type       cmd,
   input  dp_sts_type       sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARM_WR,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT_MORE,
      ST_EMIT_END
   } state_type;

   state_type        state_ff, state_in;
   logic             tready_ff, tready_in;
   logic             tvalid_ff, tvalid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pend_ff, pend_in;
   logic             accept;
   logic             next_full;

   assign accept    = req_tvalid && tready_ff;
   assign next_full = (count_ff + 1'b1) == CNT_W'(MAX_RESULTS);

   always_comb begin
      state_in  = state_ff;
      tready_in = tready_ff;
      tvalid_in = tvalid_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (req_command == CMD_ARM) begin
                  state_in  = ST_ARM_WR;
                  tready_in = 1'b0;
               end else if (req_command == CMD_DISARM) begin
                  cmd.disarm = 1'b1;
               end else if (req_command == CMD_TICK) begin
                  cmd.scan_start = 1'b1;
                  count_in       = '0;
                  pend_in        = 1'b0;
                  state_in       = ST_SCAN;
                  tready_in      = 1'b0;
               end
            end
         end
         ST_ARM_WR: begin
            cmd.arm_write = 1'b1;
            state_in      = ST_IDLE;
            tready_in     = 1'b1;
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (pend_ff) begin
               tvalid_in = 1'b1;
               if (sts.found) begin
                  state_in = ST_EMIT_MORE;
               end else begin
                  cmd.set_last = 1'b1;
                  state_in     = ST_EMIT_END;
               end
            end else if (sts.found) begin
               cmd.load_best = 1'b1;
               count_in      = count_ff + 1'b1;
               pend_in       = 1'b1;
               if (next_full) begin
                  cmd.set_last = 1'b1;
                  tvalid_in    = 1'b1;
                  state_in     = ST_EMIT_END;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end else begin
               cmd.load_none = 1'b1;
               tvalid_in     = 1'b1;
               state_in      = ST_EMIT_END;
            end
         end
         ST_EMIT_MORE: begin
            if (rsp_tready) begin
               cmd.load_best = 1'b1;
               count_in      = count_ff + 1'b1;
               if (next_full) begin
                  cmd.set_last = 1'b1;
                  state_in     = ST_EMIT_END;
               end else begin
                  cmd.scan_start = 1'b1;
                  tvalid_in      = 1'b0;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_EMIT_END: begin
            if (rsp_tready) begin
               tvalid_in = 1'b0;
               tready_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in  = ST_IDLE;
            tready_in = 1'b1;
            tvalid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tready_ff <= 1'b1;
         tvalid_ff <= 1'b0;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tready_ff <= tready_in;
         tvalid_ff <= tvalid_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
      end
   end

   assign req_tready = tready_ff;
   assign rsp_tvalid = tvalid_ff;

   // Input and result sides are never open at the same time.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(tready_ff && tvalid_ff))
      else $error("input ready while a result is shown");

   // A tick never fires more results than allowed.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RESULTS))
      else $error("fire count overflow");

   // The best candidate is only taken when one was found.
   a_load_found: assert property (@(posedge clock) disable iff (reset)
      cmd.load_best |-> sts.found)
      else $error("load without a due slot");

   // A scan only completes while the controller waits for it.
   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      sts.scan_done |-> (state_ff == ST_SCAN))
      else $error("scan finished outside the scan state");

endmodule

[hdl/one_shot_timeout_scheduler.sv]
// One-shot timeout scheduler: a table of SLOTS timer slots, each with an active
// mark, an expiry time and the time it was armed, all in nanoseconds.
// Input channel (req_): one item per command. An arm item sets a slot to expire
// at now plus delay_seconds times TICKS_PER_SECOND, a disarm item clears the
// slot, and a tick item fires every armed slot whose expiry is not after now.
// Result channel (rsp_): a tick yields its fired slots, earliest expiry first
// and ties to the lower slot, each disarmed as it fires; rsp_tlast marks the
// final one. A tick with nothing due yields one result with fired low.
// A disarm clears the active mark at acceptance; an arm first registers the delay
// product and then writes the table. A tick walks the whole slot table once for
// each result plus once to find that no more are due, unless MAX_RESULTS results
// end it first. The timer table has a single read port, so each pass reads the
// slots in turn.
// One item is in work at a time: req_tready is low from the acceptance of an
// arm or tick until its work is done and, for a tick, its last result is taken.
// When the receiver stalls, the shown result holds and the scan waits.
// Reset clears all active marks and returns both channels to idle; the timer
// table itself is not cleared, since rows of unarmed slots never become candidates.
module one_shot_timeout_scheduler import oss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // Input item channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // command[1:0], slot[6:2], delay_seconds[22:7], now[84:23], zero pad above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Result item channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // fired[0], fired_slot[5:1], expiry_time[68:6], armed_time[131:69], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   logic [CMD_W-1:0]   req_command;
   logic [SLOT_FW-1:0] req_slot;
   logic [DELAY_W-1:0] req_delay_seconds;
   logic [NOW_W-1:0]   req_now;

   logic               rsp_fired;
   logic [SLOT_FW-1:0] rsp_fired_slot;
   logic [TIME_W-1:0]  rsp_expiry_time;
   logic [TIME_W-1:0]  rsp_armed_time;

   dp_cmd_type         dp_cmd;
   dp_sts_type         dp_sts;

   // Unpack the input item fields from the lowest bit up.
   assign req_command       = req_tdata[CMD_W-1:0];
   assign req_slot          = req_tdata[CMD_W +: SLOT_FW];
   assign req_delay_seconds = req_tdata[CMD_W + SLOT_FW +: DELAY_W];
   assign req_now           = req_tdata[CMD_W + SLOT_FW + DELAY_W +: NOW_W];

   // The controller sequences arm writes, table scans and result hand-off.
   oss_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_command),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (dp_cmd),
      .sts         (dp_sts)
   );

   // The datapath holds the slot table, the scan compare and the result register.
   oss_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .sts               (dp_sts),
      .req_slot          (req_slot),
      .req_delay_seconds (req_delay_seconds),
      .req_now           (req_now),
      .rsp_fired         (rsp_fired),
      .rsp_fired_slot    (rsp_fired_slot),
      .rsp_expiry_time   (rsp_expiry_time),
      .rsp_armed_time    (rsp_armed_time),
      .rsp_last          (rsp_tlast)
   );

   // Pack the result fields from the lowest bit up, zero filled to whole bytes.
   assign rsp_tdata = {{RSP_PAD{1'b0}}, rsp_armed_time, rsp_expiry_time,
                       rsp_fired_slot, rsp_fired};

endmodule
